// ===== design/srm_pkg.sv =====
// Shared constants for the segment tree range-maximum block.
`default_nettype none

package srm_pkg;

  // Field widths of the stream words and the count register
  localparam int POS_W = 10;
  localparam int VAL_W = 31;
  localparam int CNT_W = 11;

  // Bit offsets of the input fields inside s_axis_tdata
  localparam int POS_LSB = 0;
  localparam int VAL_LSB = POS_LSB + POS_W;
  localparam int QLO_LSB = VAL_LSB + VAL_W;
  localparam int QHI_LSB = QLO_LSB + POS_W;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 32;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1;

  // Request kinds carried in s_axis_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== design/segment_tree_range_max_top.sv =====
// Max segment tree with point writes and inclusive range-maximum queries.
//
// The block keeps a max segment tree over element_count positions (node 1 is the root,
// children of node k are 2k and 2k+1, a node over lo..hi splits at (lo+hi)/2). Each input
// word on the s_axis side is either a write (tuser = 0: store value at position and refresh
// every ancestor) or a query (tuser = 1: return the maximum over range_low..range_high).
// Every input word yields exactly one output word: a query answer with tuser = 1, or a write
// acknowledgement with tuser = 0 and zero data. Positions at or beyond the live count are
// ignored, and an empty range answers 0. All node values sit in one on-chip memory of
// 2**(clog2(leaves)+1) entries (2048 for the default of 1024 elements) with a registered
// read. Items are processed one at a time: a write walks down to its leaf level by level,
// writes the leaf, then goes back up level by level (read the sibling, write the parent);
// a query walks the tree depth-first with a small frame stack, one node per cycle, and
// reads each fully covered node. The memory port is the limit: one node access per cycle.
// After reset, and after each write to the count register, the memory is swept to zero
// one entry per cycle; s_axis_tready stays low during the sweep. A finished result waits
// in an output register, so the next word is accepted while the previous answer is
// still unclaimed.
`default_nettype none

module segment_tree_range_max_top #(
  parameter int MAX_ELEMENTS = srm_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Count register write port
  input  wire logic                            cfg_we,
  input  wire logic [srm_pkg::CNT_W-1:0]       cfg_data,      // element_count
  // Request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: position[9:0], value[40:10], range_low[50:41], range_high[60:51]
  input  wire logic [srm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic [0:0]                      s_axis_tuser,  // req_type
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [srm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // max_value[30:0]
  output logic [0:0]                           m_axis_tuser   // is_answer
);

  localparam int CNT_W   = srm_pkg::CNT_W;
  localparam int VAL_W   = srm_pkg::VAL_W;
  localparam int POS_W   = srm_pkg::POS_W;
  // Largest count the register can express bounds the tree as well
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int LEAVES  = (MAX_ELEMENTS < CNT_MAX) ? MAX_ELEMENTS : CNT_MAX;
  localparam int LEAF_W  = $clog2(LEAVES);
  localparam int ADDR_W  = LEAF_W + 1;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int STACK_D = ADDR_W;
  localparam int IDX_W   = $clog2(STACK_D);
  localparam int SP_W    = $clog2(STACK_D + 1);
  localparam logic [CNT_W-1:0]  LEAVES_C = CNT_W'(LEAVES);
  localparam logic [ADDR_W-1:0] ROOT     = ADDR_W'(1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,  // zero sweep over the node memory
    S_IDLE  = 9'b000000010,  // wait for a request word
    S_DESC  = 9'b000000100,  // write: walk down to the leaf
    S_LEAF  = 9'b000001000,  // write: store the leaf
    S_URD   = 9'b000010000,  // write: read the sibling
    S_UWR   = 9'b000100000,  // write: store the parent maximum
    S_QRY   = 9'b001000000,  // query: depth-first node walk
    S_QEND  = 9'b010000000,  // query: fold the last read
    S_DONE  = 9'b100000000   // hand the result to the output register
  } state_t;

  state_t state;

  // Node memory
  logic [VAL_W-1:0]  mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [VAL_W-1:0]  rdata;

  // Control and working registers
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] node;
  logic [LEAF_W-1:0] lo;
  logic [LEAF_W-1:0] hi;
  logic [LEAF_W-1:0] pos_r;
  logic [LEAF_W-1:0] ql;
  logic [LEAF_W-1:0] qh;
  logic [VAL_W-1:0]  acc;
  logic              rd_pend;
  logic              is_ans;
  logic [SP_W-1:0]   sp;
  logic [ADDR_W-1:0] stk_node [STACK_D];
  logic [LEAF_W-1:0] stk_lo   [STACK_D];
  logic [LEAF_W-1:0] stk_hi   [STACK_D];

  // Output register
  logic              out_valid;
  logic              out_answer;
  logic [VAL_W-1:0]  out_value;

  // Request fields
  logic              in_req;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic [POS_W-1:0]  in_ql;
  logic [POS_W-1:0]  in_qh;

  // Datapath
  logic [CNT_W-1:0]  n_live;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  qh_ext;
  logic [CNT_W-1:0]  qh_clip;
  logic              wr_ok;
  logic              q_ok;
  logic [LEAF_W:0]   span_sum;
  logic [LEAF_W-1:0] mid;
  logic [LEAF_W-1:0] mid_p1;
  logic              disjoint;
  logic              covered;
  logic [VAL_W-1:0]  rd_max;
  logic [VAL_W-1:0]  upd_max;
  logic [SP_W-1:0]   sp_dec;
  logic [IDX_W-1:0]  pop_idx;
  logic [IDX_W-1:0]  push_idx;

  assign in_req = s_axis_tuser[0];
  assign in_pos = s_axis_tdata[srm_pkg::POS_LSB +: POS_W];
  assign in_val = s_axis_tdata[srm_pkg::VAL_LSB +: VAL_W];
  assign in_ql  = s_axis_tdata[srm_pkg::QLO_LSB +: POS_W];
  assign in_qh  = s_axis_tdata[srm_pkg::QHI_LSB +: POS_W];

  // A count beyond the tree size acts as the tree size
  assign n_live  = (count > LEAVES_C) ? LEAVES_C : count;
  assign n_m1    = n_live - CNT_W'(1);
  assign wr_ok   = (n_live != '0) && (CNT_W'(in_pos) < n_live);
  // Clip the query to the live positions; the walk then never leaves the root span
  assign qh_ext  = CNT_W'(in_qh);
  assign qh_clip = (qh_ext > n_m1) ? n_m1 : qh_ext;
  assign q_ok    = (n_live != '0) && (CNT_W'(in_ql) <= qh_clip);

  assign span_sum = {1'b0, lo} + {1'b0, hi};
  assign mid      = span_sum[LEAF_W:1];
  assign mid_p1   = mid + LEAF_W'(1);
  assign disjoint = (ql > hi) || (qh < lo);
  assign covered  = (ql <= lo) && (qh >= hi);
  assign rd_max   = (rd_pend && (rdata > acc)) ? rdata : acc;
  assign upd_max  = (rdata > acc) ? rdata : acc;

  assign sp_dec   = sp - SP_W'(1);
  assign pop_idx  = sp_dec[IDX_W-1:0];
  assign push_idx = sp[IDX_W-1:0];

  // Memory port selection. A write refresh reads only siblings of nodes on its own path,
  // which that refresh never writes, so no forwarding is needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = acc;
    mem_re    = 1'b0;
    mem_raddr = node;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_LEAF: begin
        mem_we = 1'b1;
      end
      S_URD: begin
        mem_re    = 1'b1;
        mem_raddr = {node[ADDR_W-1:1], ~node[0]};
      end
      S_UWR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, node[ADDR_W-1:1]};
        mem_wdata = upd_max;
      end
      S_QRY: begin
        mem_re = covered;
      end
      S_IDLE, S_DESC, S_QEND, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= srm_pkg::COUNT_RESET;
      out_valid <= 1'b0;
      sp        <= '0;
      rd_pend   <= 1'b0;
    end else begin
      // Drop the held result once it is taken; a finishing item reloads it instead
      if (m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      // A new count changes the tree shape: wipe every node
      if (cfg_we) begin
        count    <= cfg_data;
        clr_addr <= '0;
        state    <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + ADDR_W'(1);
            if (clr_addr == ADDR_W'(DEPTH - 1)) begin
              state <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (s_axis_tvalid) begin
              node    <= ROOT;
              lo      <= '0;
              hi      <= LEAF_W'(n_m1);
              rd_pend <= 1'b0;
              sp      <= '0;
              if (in_req == srm_pkg::REQ_WRITE) begin
                is_ans <= 1'b0;
                acc    <= in_val;
                pos_r  <= LEAF_W'(in_pos);
                state  <= wr_ok ? S_DESC : S_DONE;
              end else begin
                is_ans <= 1'b1;
                acc    <= '0;
                ql     <= LEAF_W'(in_ql);
                qh     <= LEAF_W'(qh_clip);
                state  <= q_ok ? S_QRY : S_DONE;
              end
            end
          end

          S_DESC: begin
            if (lo == hi) begin
              state <= S_LEAF;
            end else if (pos_r <= mid) begin
              node <= {node[ADDR_W-2:0], 1'b0};
              hi   <= mid;
            end else begin
              node <= {node[ADDR_W-2:0], 1'b1};
              lo   <= mid_p1;
            end
          end

          S_LEAF: begin
            state <= (node == ROOT) ? S_DONE : S_URD;
          end

          S_URD: begin
            state <= S_UWR;
          end

          S_UWR: begin
            acc  <= upd_max;
            node <= {1'b0, node[ADDR_W-1:1]};
            state <= ({1'b0, node[ADDR_W-1:1]} == ROOT) ? S_DONE : S_URD;
          end

          S_QRY: begin
            acc     <= rd_max;
            rd_pend <= covered;
            if (disjoint || covered) begin
              if (sp == '0) begin
                state <= S_QEND;
              end else begin
                node <= stk_node[pop_idx];
                lo   <= stk_lo[pop_idx];
                hi   <= stk_hi[pop_idx];
                sp   <= sp_dec;
              end
            end else begin
              // Park the right half, descend into the left half
              stk_node[push_idx] <= {node[ADDR_W-2:0], 1'b1};
              stk_lo[push_idx]   <= mid_p1;
              stk_hi[push_idx]   <= hi;
              sp   <= sp + SP_W'(1);
              node <= {node[ADDR_W-2:0], 1'b0};
              hi   <= mid;
            end
          end

          S_QEND: begin
            acc     <= rd_max;
            rd_pend <= 1'b0;
            state   <= S_DONE;
          end

          S_DONE: begin
            if (!out_valid || m_axis_tready) begin
              out_valid  <= 1'b1;
              out_answer <= is_ans;
              out_value  <= is_ans ? acc : '0;
              state      <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign s_axis_tready   = (state == S_IDLE);
  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {{(srm_pkg::OUT_DATA_W - VAL_W){1'b0}}, out_value};
  assign m_axis_tuser[0] = out_answer;

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_D))
    else $error("frame stack overflow");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (!s_axis_tready && state == S_CLEAR))
    else $error("count write did not start the zero sweep");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == srm_pkg::REQ_WRITE) |-> m_axis_tdata == '0)
    else $error("write acknowledgement carries data");

  a_pend_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(mem_re))
    else $error("fold of a node value without a read");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("node memory written while idle");
`endif

endmodule

`default_nettype wire
